// File: sv/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, ignored while reset is low.
`define ASSERT_IMPLY(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: sv/kmh_pkg.sv
`timescale 1ns / 1ps
package kmh_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = 64;
    localparam int PAY_W = 15;
    localparam int ENT_W = KEY_W + 2 * PAY_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELMAX = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_INVALID   = 3'd6;
    localparam logic [2:0] ST_FULL      = 3'd7;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] players;
        logic [PAY_W-1:0] duration;
    } entry_t;
endpackage

// File: sv/keyed_max_heap_with_update.sv
`timescale 1ns / 1ps
// Keyed max-heap priority queue with payload update.
// Input channel s_axis_*: tdata holds, from bit 0 up, cmd[1:0], key[65:2],
// players[81:66], duration[97:82], zero padded to 104 bits. cmd 0 inserts or
// updates, cmd 1 removes the entry with the largest key, cmd 2 looks a key up.
// Result channel m_axis_*: one item per input item; tdata holds status[2:0],
// out_key[66:3], out_players[81:67], out_duration[96:82], padded to 104 bits.
// Entries sit in one synchronous RAM with one write port, one read port and a
// registered read. One item is processed at a time and the RAM sets the timing:
// the key search reads the live entries one after another, sift-up reads one
// parent per level and sift-down reads the left and, if present, the right child
// per level; a delete first reads the root and then the last entry. An invalid
// item, or any item on an empty heap, goes straight to the result state.
// Reset clears the state, the entry count and the result valid flag only; RAM contents are never read unless live.
// A finished result sits in the output register while the receiver stalls;
// the next item can be taken in the cycle after that result has been accepted.
module keyed_max_heap_with_update
    import kmh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // cmd, key, players, duration
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // status, out_key, out_players, out_duration
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;  // search read issued, compare next
    localparam logic [3:0] S_UPW    = 4'd2;  // parent read, compare and move
    localparam logic [3:0] S_DROOT  = 4'd3;  // root data returning
    localparam logic [3:0] S_DLAST  = 4'd4;  // last entry returning
    localparam logic [3:0] S_DLEFT  = 4'd5;  // left child returning
    localparam logic [3:0] S_DRIGHT = 4'd6;  // right child returning
    localparam logic [3:0] S_DONE   = 4'd7;
    localparam logic [3:0] S_UPFIND = 4'd8;  // final write of the item into the hole

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        cmd_reg, cmd_next;
    entry_t            item_reg, item_next;     // entry being placed
    logic [IDX_W-1:0]  idx_reg, idx_next;       // search index or hole
    logic [KEY_W-1:0]  lkey_reg, lkey_next;     // left child key
    entry_t            lent_reg, lent_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        st_reg, st_next;
    entry_t            res_reg, res_next;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    entry_t            wdata, rdata;

    kmh_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [1:0]        in_cmd;
    logic [KEY_W-1:0]  in_key;
    logic [15:0]       in_pl, in_du;
    logic              pay_ok;
    logic [IDX_W:0]    child_l;
    logic [IDX_W-1:0]  parent;

    assign in_cmd = s_axis_tdata[1:0];
    assign in_key = s_axis_tdata[65:2];
    assign in_pl  = s_axis_tdata[81:66];
    assign in_du  = s_axis_tdata[97:82];
    assign pay_ok = (in_pl != 16'd0) && !in_pl[15] && (in_du != 16'd0) && !in_du[15];
    assign child_l = {idx_reg, 1'b1};
    assign parent  = IDX_W'((idx_reg - 1'b1) >> 1);

    assign s_axis_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg.duration, res_reg.players, res_reg.key, st_reg};

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        lkey_next    = lkey_reg;
        lent_next    = lent_reg;
        m_valid_next = m_valid_reg;
        st_next      = st_reg;
        res_next     = res_reg;
        we    = 1'b0;
        waddr = idx_reg;
        wdata = item_reg;
        raddr = idx_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    cmd_next  = in_cmd;
                    item_next = '{key: in_key, players: in_pl[PAY_W-1:0],
                                  duration: in_du[PAY_W-1:0]};
                    idx_next  = '0;
                    raddr     = '0;
                    res_next  = '0;
                    if ((in_cmd == CMD_INSERT && !pay_ok) ||
                        (in_cmd != CMD_INSERT && in_cmd != CMD_DELMAX &&
                         in_cmd != CMD_LOOKUP)) begin
                        st_next = ST_INVALID;
                        state_next = S_DONE;
                    end else if (in_cmd == CMD_DELMAX) begin
                        if (count_reg == '0) begin
                            st_next = ST_EMPTY;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_DROOT;
                        end
                    end else if (count_reg == '0) begin
                        if (in_cmd == CMD_LOOKUP) begin
                            st_next = ST_NOT_FOUND;
                            state_next = S_DONE;
                        end else begin
                            we = 1'b1;
                            waddr = '0;
                            wdata = '{key: in_key, players: in_pl[PAY_W-1:0],
                                      duration: in_du[PAY_W-1:0]};
                            count_next = CNT_W'(1);
                            st_next = ST_INSERTED;
                            state_next = S_DONE;
                        end
                    end else begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                // rdata holds entry idx_reg
                if (rdata.key == item_reg.key) begin
                    if (cmd_reg == CMD_LOOKUP) begin
                        res_next = rdata;
                        st_next = ST_FOUND;
                    end else begin
                        we = 1'b1;
                        wdata = '{key: rdata.key, players: item_reg.players,
                                  duration: item_reg.duration};
                        st_next = ST_UPDATED;
                    end
                    state_next = S_DONE;
                end else if (CNT_W'(idx_reg) + 1'b1 < count_reg) begin
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_reg + 1'b1;
                end else if (cmd_reg == CMD_LOOKUP) begin
                    st_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    st_next = ST_FULL;
                    state_next = S_DONE;
                end else begin
                    idx_next = IDX_W'(count_reg);
                    raddr = IDX_W'((count_reg - 1'b1) >> 1);
                    count_next = count_reg + 1'b1;
                    st_next = ST_INSERTED;
                    state_next = S_UPW;
                end
            end
            S_UPW: begin
                // rdata holds the parent of hole idx_reg (idx_reg > 0)
                if (item_reg.key > rdata.key) begin
                    we = 1'b1;
                    wdata = rdata;
                    idx_next = parent;
                    if (parent == '0) begin
                        state_next = S_UPFIND;
                    end else begin
                        raddr = IDX_W'((parent - 1'b1) >> 1);
                    end
                end else begin
                    we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_UPFIND: begin
                we = 1'b1;
                state_next = S_DONE;
            end
            S_DROOT: begin
                res_next = rdata;
                st_next = ST_REMOVED;
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1)) begin
                    state_next = S_DONE;
                end else begin
                    raddr = IDX_W'(count_reg - 1'b1);
                    state_next = S_DLAST;
                end
            end
            S_DLAST: begin
                item_next = rdata;
                idx_next = '0;
                if (count_reg > CNT_W'(1)) begin
                    raddr = IDX_W'(1);
                    state_next = S_DLEFT;
                end else begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = rdata;
                    state_next = S_DONE;
                end
            end
            S_DLEFT: begin
                lent_next = rdata;
                lkey_next = rdata.key;
                if ((child_l + 1'b1) < (IDX_W + 1)'(count_reg)) begin
                    raddr = IDX_W'(child_l + 1'b1);
                    state_next = S_DRIGHT;
                end else if (rdata.key > item_reg.key) begin
                    we = 1'b1;
                    wdata = rdata;
                    idx_next = IDX_W'(child_l);
                    state_next = S_UPFIND;
                end else begin
                    we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DRIGHT: begin
                if (rdata.key > lkey_reg && rdata.key > item_reg.key) begin
                    we = 1'b1;
                    wdata = rdata;
                    idx_next = IDX_W'(child_l + 1'b1);
                end else if (!(rdata.key > lkey_reg) && lkey_reg > item_reg.key) begin
                    we = 1'b1;
                    wdata = lent_reg;
                    idx_next = IDX_W'(child_l);
                end else begin
                    we = 1'b1;
                    state_next = S_DONE;
                end
                if (state_next != S_DONE) begin
                    // next hole's left child
                    if ((({idx_next, 1'b1}) < (IDX_W + 2)'(count_reg))) begin
                        raddr = IDX_W'({idx_next, 1'b1});
                        state_next = S_DLEFT;
                    end else begin
                        state_next = S_UPFIND;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg  <= cmd_next;
        item_reg <= item_next;
        idx_reg  <= idx_next;
        lkey_reg <= lkey_next;
        lent_reg <= lent_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
    end
endmodule

// File: sv/kmh_ram.sv
`timescale 1ns / 1ps
module kmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/kmh_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kmh_checker
    import kmh_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    // A stalled result holds.
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
    // Items are processed one at a time.
    `ASSERT_IMPLY(a_excl, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "input taken with result pending")
    // An accepted item never gives a result in the same or next cycle.
    `ASSERT_NEXT(a_lat, aclk, aresetn, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result too early")
    // Key and payload fields come back zero when status reports no entry.
    `ASSERT_IMPLY(a_zero, aclk, aresetn, m_axis_tvalid && (m_axis_tdata[2:0] != ST_REMOVED) && (m_axis_tdata[2:0] != ST_FOUND), m_axis_tdata[96:3] == '0, "payload not cleared")
endmodule

bind keyed_max_heap_with_update kmh_checker u_kmh_checker (.*);
